>>> src/owsp_pkg.sv
// Shared constants and types for the omni wheel step planner.
package owsp_pkg;

  localparam int STEP_BITS_DEF       = 21;
  localparam int RATIO_FRAC_BITS_DEF = 15;

  localparam int CMD_W    = 16;
  localparam int ASCENT_W = 16;
  localparam int RAMP_W   = 16;

  // Q16 gains over the distance per pulse
  localparam int GAIN_W = 22;
  localparam int PROD_W = GAIN_W + CMD_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int Q_FRAC = 16;

  localparam logic signed [GAIN_W-1:0] GAIN_UNIT = 22'sd1198888;
  localparam logic signed [GAIN_W-1:0] GAIN_HALF = 22'sd599444;
  localparam logic signed [GAIN_W-1:0] GAIN_Y    = 22'sd1031043;
  localparam logic signed [GAIN_W-1:0] GAIN_TURN = 22'sd1918220;

  localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(32768);

  localparam logic [RAMP_W-1:0] SHORT_MOVE_TRIM = 16'd3200;

  localparam int NUM_WHEELS = 3;

  typedef enum logic [1:0] {
    WHEEL_0 = 2'd0,
    WHEEL_1 = 2'd1,
    WHEEL_2 = 2'd2
  } wheel_idx_t;

endpackage

>>> src/owsp_ifs.sv
// Channel interfaces: move command, move plan and configuration write.
interface owsp_cmd_if;
  import owsp_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [CMD_W-1:0] move_x;
  logic signed [CMD_W-1:0] move_y;
  logic signed [CMD_W-1:0] turn_angle;

  modport source(output valid, output move_x, output move_y, output turn_angle, input ready);
  modport sink(input valid, input move_x, input move_y, input turn_angle, output ready);
endinterface

interface owsp_plan_if #(
  parameter int STEP_BITS = owsp_pkg::STEP_BITS_DEF,
  parameter int RATIO_W   = owsp_pkg::RATIO_FRAC_BITS_DEF + 1
);
  import owsp_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [STEP_BITS-1:0] wheel0_steps;
  logic [STEP_BITS-1:0] wheel1_steps;
  logic [STEP_BITS-1:0] wheel2_steps;
  logic                 wheel0_dir;
  logic                 wheel1_dir;
  logic                 wheel2_dir;
  logic [1:0]           leading_wheel;
  logic [STEP_BITS-1:0] leading_steps;
  logic [RATIO_W-1:0]   wheel0_ratio;
  logic [RATIO_W-1:0]   wheel1_ratio;
  logic [RATIO_W-1:0]   wheel2_ratio;
  logic [RAMP_W-1:0]    ramp_steps;

  modport source(
    output valid, input ready,
    output wheel0_steps, output wheel1_steps, output wheel2_steps,
    output wheel0_dir, output wheel1_dir, output wheel2_dir,
    output leading_wheel, output leading_steps,
    output wheel0_ratio, output wheel1_ratio, output wheel2_ratio,
    output ramp_steps
  );
  modport sink(
    input valid, output ready,
    input wheel0_steps, input wheel1_steps, input wheel2_steps,
    input wheel0_dir, input wheel1_dir, input wheel2_dir,
    input leading_wheel, input leading_steps,
    input wheel0_ratio, input wheel1_ratio, input wheel2_ratio,
    input ramp_steps
  );
endinterface

interface owsp_cfg_if;
  import owsp_pkg::*;
  logic                valid;
  logic                ready;
  logic [ASCENT_W-1:0] ascent_steps;

  modport source(output valid, output ascent_steps, input ready);
  modport sink(input valid, input ascent_steps, output ready);
endinterface

>>> src/owsp_ratio_div.sv
// Pipelined restoring divider: three wheel-to-leader ratios, one quotient bit per stage.
module owsp_ratio_div #(
  parameter int STEP_BITS       = owsp_pkg::STEP_BITS_DEF,
  parameter int RATIO_FRAC_BITS = owsp_pkg::RATIO_FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic [RATIO_FRAC_BITS+1:0]   load,
  input  logic [STEP_BITS-1:0]         steps_i [owsp_pkg::NUM_WHEELS],
  input  logic [STEP_BITS-1:0]         lead_i,
  output logic [RATIO_FRAC_BITS:0]     ratio_o [owsp_pkg::NUM_WHEELS]
);
  import owsp_pkg::*;

  localparam int FRAC = RATIO_FRAC_BITS;
  localparam int RW   = FRAC + 1;
  localparam int DS   = FRAC + 2;
  localparam int NW   = STEP_BITS + FRAC + 1;

  // acc holds {partial remainder, unused dividend bits, quotient bits so far}
  logic [NW-1:0]        acc_r  [DS][NUM_WHEELS];
  logic [STEP_BITS-1:0] lead_r [DS];

  // numerator with half the divisor added for round to nearest
  always_ff @(posedge clk) begin
    if (load[0]) begin
      lead_r[0] <= lead_i;
      for (int i = 0; i < NUM_WHEELS; i++) begin
        acc_r[0][i] <= {1'b0, steps_i[i], {FRAC{1'b0}}} + NW'(lead_i >> 1);
      end
    end
  end

  for (genvar k = 1; k < DS; k++) begin : g_stage
    logic [NW-1:0] acc_nxt [NUM_WHEELS];

    always_comb begin
      logic [STEP_BITS:0] trial;
      logic [STEP_BITS:0] diff;
      for (int i = 0; i < NUM_WHEELS; i++) begin
        trial = acc_r[k-1][i][NW-1:FRAC];
        diff  = trial - {1'b0, lead_r[k-1]};
        if (trial >= {1'b0, lead_r[k-1]}) begin
          acc_nxt[i] = {diff[STEP_BITS-1:0], acc_r[k-1][i][FRAC-1:0], 1'b1};
        end else begin
          acc_nxt[i] = {trial[STEP_BITS-1:0], acc_r[k-1][i][FRAC-1:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (load[k]) begin
        lead_r[k] <= lead_r[k-1];
        for (int i = 0; i < NUM_WHEELS; i++) begin
          acc_r[k][i] <= acc_nxt[i];
        end
      end
    end
  end

  // a zero leader gives zero ratios
  always_comb begin
    for (int i = 0; i < NUM_WHEELS; i++) begin
      ratio_o[i] = (lead_r[DS-1] == '0) ? '0 : acc_r[DS-1][i][RW-1:0];
    end
  end

endmodule

>>> src/omni_wheel_step_planner.sv
// Move planner for a three-wheel omni base: pulse counts, directions, leader, ratios, ramp.
// One move command (x, y, turn angle) turns into three wheel pulse counts with direction
// pins, the leading wheel and its count, each wheel's speed ratio to the leader and the
// ramp length. A new command is taken every clock cycle unless the output is stalled and the
// pipeline is full; each result passes the gain, sum, saturation and leader stages and then
// the ratio divider, which sets the depth and resolves one quotient bit per pipeline stage.
// Stages that hold no command fill up while the output is stalled, so the input stays open
// until the whole pipeline is full. The ascent register is written through its own channel,
// which is always ready, and should be changed only while no command is in flight.
module omni_wheel_step_planner #(
  parameter int STEP_BITS       = owsp_pkg::STEP_BITS_DEF,
  parameter int RATIO_FRAC_BITS = owsp_pkg::RATIO_FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  owsp_cmd_if.sink      in_cmd,
  owsp_plan_if.source   out_plan,
  owsp_cfg_if.sink      cfg_wr
);
  import owsp_pkg::*;

  localparam int DS = RATIO_FRAC_BITS + 2;
  localparam int NS = 4 + DS;
  localparam int QW = SUM_W - Q_FRAC;
  localparam int CW = (QW > STEP_BITS) ? QW : STEP_BITS;
  localparam logic [CW-1:0] STEP_LIM = CW'((64'd1 << STEP_BITS) - 64'd1);

  typedef struct packed {
    logic [STEP_BITS-1:0] steps0;
    logic [STEP_BITS-1:0] steps1;
    logic [STEP_BITS-1:0] steps2;
    logic [2:0]           dir;
    wheel_idx_t           lead_idx;
    logic [STEP_BITS-1:0] lead;
    logic [RAMP_W-1:0]    ramp;
  } side_t;

  logic [ASCENT_W-1:0] ascent_r;
  logic [NS-1:0]       v_r;
  logic [NS:0]         load;

  logic signed [PROD_W-1:0] p_ux_r, p_hx_r, p_yy_r, p_ta_r;
  logic signed [SUM_W-1:0]  t_r [NUM_WHEELS];
  logic [STEP_BITS-1:0]     steps_r [NUM_WHEELS];
  logic [2:0]               dir_r;
  side_t                    side_r;
  side_t                    side_d_r [DS];

  logic signed [SUM_W-1:0]  t_nxt [NUM_WHEELS];
  logic [STEP_BITS-1:0]     steps_nxt [NUM_WHEELS];
  logic [2:0]               dir_nxt;
  side_t                    side_nxt;
  logic [STEP_BITS-1:0]     div_steps [NUM_WHEELS];
  logic [RATIO_FRAC_BITS:0] ratio [NUM_WHEELS];

  // configuration register
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ascent_r <= '0;
    end else if (cfg_wr.valid) begin
      ascent_r <= cfg_wr.ascent_steps;
    end
  end

  // a stage loads when it is empty or its content moves on
  always_comb begin
    load[NS] = out_plan.ready;
    for (int k = NS - 1; k >= 0; k--) begin
      load[k] = !v_r[k] || load[k+1];
    end
  end

  assign in_cmd.ready = load[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (load[0]) begin
        v_r[0] <= in_cmd.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (load[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // stage 1: gain products
  always_ff @(posedge clk) begin
    if (load[0]) begin
      p_ux_r <= PROD_W'(GAIN_UNIT) * PROD_W'(in_cmd.move_x);
      p_hx_r <= PROD_W'(GAIN_HALF) * PROD_W'(in_cmd.move_x);
      p_yy_r <= PROD_W'(GAIN_Y) * PROD_W'(in_cmd.move_y);
      p_ta_r <= PROD_W'(GAIN_TURN) * PROD_W'(in_cmd.turn_angle);
    end
  end

  // stage 2: per-wheel Q16 sums plus one half
  assign t_nxt[0] = SUM_W'(p_ux_r) + SUM_W'(p_ta_r) + ROUND_HALF;
  assign t_nxt[1] = SUM_W'(p_ta_r) - SUM_W'(p_hx_r) - SUM_W'(p_yy_r) + ROUND_HALF;
  assign t_nxt[2] = SUM_W'(p_ta_r) - SUM_W'(p_hx_r) + SUM_W'(p_yy_r) + ROUND_HALF;

  always_ff @(posedge clk) begin
    if (load[1]) begin
      for (int i = 0; i < NUM_WHEELS; i++) begin
        t_r[i] <= t_nxt[i];
      end
    end
  end

  // stage 3: truncate toward zero, take magnitude, saturate
  always_comb begin
    logic [SUM_W-1:0] mag;
    logic [CW-1:0]    q;
    logic [2:0]       pos;
    logic [2:0]       neg;
    for (int i = 0; i < NUM_WHEELS; i++) begin
      mag          = t_r[i][SUM_W-1] ? SUM_W'(-t_r[i]) : SUM_W'(t_r[i]);
      q            = CW'(mag[SUM_W-1:Q_FRAC]);
      steps_nxt[i] = (q > STEP_LIM) ? STEP_BITS'(STEP_LIM) : STEP_BITS'(q);
      pos[i]       = !t_r[i][SUM_W-1] && (q != '0);
      neg[i]       = t_r[i][SUM_W-1] && (q != '0);
    end
    dir_nxt = {pos[2], neg[1], pos[0]};
  end

  always_ff @(posedge clk) begin
    if (load[2]) begin
      dir_r <= dir_nxt;
      for (int i = 0; i < NUM_WHEELS; i++) begin
        steps_r[i] <= steps_nxt[i];
      end
    end
  end

  // stage 4: leader pick and ramp length
  always_comb begin
    logic [STEP_BITS-1:0] half;
    side_nxt.steps0 = steps_r[0];
    side_nxt.steps1 = steps_r[1];
    side_nxt.steps2 = steps_r[2];
    side_nxt.dir    = dir_r;
    if (steps_r[0] > steps_r[1]) begin
      side_nxt.lead_idx = (steps_r[0] > steps_r[2]) ? WHEEL_0 : WHEEL_2;
    end else begin
      side_nxt.lead_idx = (steps_r[2] > steps_r[1]) ? WHEEL_2 : WHEEL_1;
    end
    side_nxt.lead = steps_r[side_nxt.lead_idx];
    half = side_nxt.lead >> 1;
    if (side_nxt.lead < STEP_BITS'(ascent_r)) begin
      if (half > STEP_BITS'(SHORT_MOVE_TRIM)) begin
        side_nxt.ramp = RAMP_W'(half - STEP_BITS'(SHORT_MOVE_TRIM));
      end else begin
        side_nxt.ramp = RAMP_W'(half);
      end
    end else begin
      side_nxt.ramp = ascent_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load[3]) begin
      side_r <= side_nxt;
    end
  end

  // ratio divider and the matching delay line for the rest of the plan
  assign div_steps[0] = side_r.steps0;
  assign div_steps[1] = side_r.steps1;
  assign div_steps[2] = side_r.steps2;

  owsp_ratio_div #(
    .STEP_BITS       (STEP_BITS),
    .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
  ) u_ratio_div (
    .clk     (clk),
    .load    (load[NS-1:4]),
    .steps_i (div_steps),
    .lead_i  (side_r.lead),
    .ratio_o (ratio)
  );

  always_ff @(posedge clk) begin
    if (load[4]) begin
      side_d_r[0] <= side_r;
    end
    for (int k = 1; k < DS; k++) begin
      if (load[4+k]) begin
        side_d_r[k] <= side_d_r[k-1];
      end
    end
  end

  assign out_plan.valid         = v_r[NS-1];
  assign out_plan.wheel0_steps  = side_d_r[DS-1].steps0;
  assign out_plan.wheel1_steps  = side_d_r[DS-1].steps1;
  assign out_plan.wheel2_steps  = side_d_r[DS-1].steps2;
  assign out_plan.wheel0_dir    = side_d_r[DS-1].dir[0];
  assign out_plan.wheel1_dir    = side_d_r[DS-1].dir[1];
  assign out_plan.wheel2_dir    = side_d_r[DS-1].dir[2];
  assign out_plan.leading_wheel = side_d_r[DS-1].lead_idx;
  assign out_plan.leading_steps = side_d_r[DS-1].lead;
  assign out_plan.wheel0_ratio  = ratio[0];
  assign out_plan.wheel1_ratio  = ratio[1];
  assign out_plan.wheel2_ratio  = ratio[2];
  assign out_plan.ramp_steps    = side_d_r[DS-1].ramp;

endmodule
